[rtl/core/tmq_pkg.sv]
// Shared types and constants for the multi-timer deadline unit.
// Used by the channel interfaces, the adder and the top level; depends on nothing.
package tmq_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int TIME_W      = 63;
   localparam int IDX_W       = 4;
   localparam int MASK_W      = 16;
   localparam int TMR_W       = $clog2(NUM_TIMERS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [TIME_W:0]   wide_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [MASK_W-1:0] mask_type;
   typedef logic [TMR_W-1:0]  tmr_type;

   localparam time_type NEVER = '1;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ARM    = 2'd1,
      OP_DISARM = 2'd2,
      OP_DONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EV_DONE   = 2'd0,
      EV_LAUNCH = 2'd1,
      EV_BUSY   = 2'd2,
      EV_WAKE   = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      REG_LAUNCH  = 2'd0,
      REG_WAKE    = 2'd1,
      REG_REALCLK = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ALU_ADD_SAT   = 2'd0,
      ALU_ADD_RAW   = 2'd1,
      ALU_SUB_CLAMP = 2'd2
   } alu_mode_type;

   typedef struct packed {
      alu_mode_type mode;
      wide_type     a;
      wide_type     b;
   } alu_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_REAL,
      ST_SCAN,
      ST_FIRE,
      ST_EMIT
   } fsm_state_type;

endpackage

[rtl/core/tmq_channels.sv]
// Valid/ready channel interfaces: operation requests, results and register writes.
// Depends on tmq_pkg for field widths.
interface tmq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   tmq_pkg::idx_type   timer_index;
   logic               absolute;
   tmq_pkg::time_type  start_value;
   tmq_pkg::time_type  period;
   tmq_pkg::time_type  now;
   tmq_pkg::time_type  real_now;

   modport source (output valid, op, timer_index, absolute, start_value, period, now,
                   real_now, input ready);
   modport sink   (input valid, op, timer_index, absolute, start_value, period, now,
                   real_now, output ready);
endinterface

interface tmq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         event_res;
   tmq_pkg::idx_type   fired_timer;
   tmq_pkg::time_type  fired_deadline;
   tmq_pkg::time_type  next_deadline;
   logic               last;

   modport source (output valid, event_res, fired_timer, fired_deadline, next_deadline,
                   last, input ready);
   modport sink   (input valid, event_res, fired_timer, fired_deadline, next_deadline,
                   last, output ready);
endinterface

interface tmq_csr_if;
   logic               valid;
   logic               ready;
   logic [1:0]         index;
   tmq_pkg::mask_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/tmq_adder.sv]
// Shared 64-bit adder with saturating add, plain add and clamped subtract modes.
// Depends on tmq_pkg for the request struct and mode codes.
module tmq_adder (
   input  tmq_pkg::alu_req_type alu_req,
   output tmq_pkg::wide_type    alu_y
);
   import tmq_pkg::*;

   logic            is_sub;
   wide_type        b_eff;
   logic [TIME_W+1:0] sum;

   // one carry chain; subtract as a plus inverted b plus one
   always_comb begin
      is_sub = (alu_req.mode == ALU_SUB_CLAMP);
      b_eff  = is_sub ? ~alu_req.b : alu_req.b;
      sum    = {1'b0, alu_req.a} + {1'b0, b_eff} + {{(TIME_W + 1){1'b0}}, is_sub};
   end

   // shape the result per mode
   always_comb begin
      case (alu_req.mode)
         ALU_ADD_SAT: begin
            if (sum[TIME_W+1] || sum[TIME_W]) begin
               alu_y = {1'b0, NEVER};
            end else begin
               alu_y = sum[TIME_W:0];
            end
         end
         ALU_ADD_RAW: begin
            alu_y = sum[TIME_W:0];
         end
         ALU_SUB_CLAMP: begin
            // no carry out means a borrow: clamp at zero
            if (!sum[TIME_W+1]) begin
               alu_y = '0;
            end else if (sum[TIME_W]) begin
               alu_y = {1'b0, NEVER};
            end else begin
               alu_y = sum[TIME_W:0];
            end
         end
         default: begin
            alu_y = '0;
         end
      endcase
   end

endmodule

[rtl/core/multi_timer_deadline_unit_top.sv]
// Top level of the multi-timer deadline unit: sequencer, timer store and result register.
// Depends on tmq_pkg, the channel interfaces in tmq_channels and tmq_adder.
//
// One operation word is taken at a time; req ready is low until its last result word
// has been taken. Every operation ends in a scan that walks the timers one per cycle
// to find the earliest armed deadline and the next due timer. Disarm and task done go
// through apply, scan and emit; arm goes through apply, then real for absolute
// real-clock times (an extra adder pass), then scan and emit; an idle tick goes through
// scan and emit. A tick that fires timers fires each one and rescans before each result
// word it emits. The unit returns to idle before the next word is taken, and any stall
// on the result side adds to this. All saturating and clamped arithmetic goes through
// one shared adder.
module multi_timer_deadline_unit_top (
   input  logic       clock,
   input  logic       reset,
   tmq_req_if.sink    req_ch,
   tmq_rsp_if.source  rsp_ch,
   tmq_csr_if.sink    csr_ch
);
   import tmq_pkg::*;

   function automatic logic mask_bit(mask_type m, tmr_type i);
      logic [7:0] wide_i;
      wide_i = 8'(i);
      return (wide_i < 8'(MASK_W)) && m[wide_i[3:0]];
   endfunction

   fsm_state_type state_ff, state_in;

   // captured request
   logic [1:0] op_ff;
   idx_type    idx_ff;
   logic       abs_ff;
   time_type   value_ff;
   time_type   per_ff;
   time_type   now_ff;
   time_type   real_now_ff;

   // configuration
   mask_type launch_ff, wake_ff, realclk_ff;

   // timer store
   time_type              deadline_mem [NUM_TIMERS];
   time_type              period_mem   [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] armed_ff;
   logic [NUM_TIMERS-1:0] busy_ff;

   // scan and tick bookkeeping
   tmr_type               scan_idx_ff;
   time_type              min_ff;
   tmr_type               cand_ff;
   time_type              cand_dl_ff;
   logic                  found_ff;
   logic [NUM_TIMERS-1:0] done_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  have_res_ff;
   wide_type              sum_ff;

   // result register
   event_type ev_ff;
   idx_type   fired_ff;
   time_type  fd_ff;
   logic      last_ff;

   logic        req_take;
   logic        scan_start;
   logic        scan_last;
   logic        scan_to_emit;
   logic        emit_last;
   logic        in_range;
   logic        arm_live;
   tmr_type     tgt;
   tmr_type     rd_addr;
   time_type    rd_dl;
   time_type    rd_per;
   logic        hit_min;
   logic        hit_due;
   logic        found_fin;
   alu_req_type alu_req;
   wide_type    alu_y;

   tmq_adder u_adder (
      .alu_req (alu_req),
      .alu_y   (alu_y)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_take     = req_ch.valid && req_ch.ready;

   // present the result word
   assign rsp_ch.valid          = (state_ff == ST_EMIT);
   assign rsp_ch.event_res      = ev_ff;
   assign rsp_ch.fired_timer    = fired_ff;
   assign rsp_ch.fired_deadline = fd_ff;
   assign rsp_ch.next_deadline  = min_ff;
   assign rsp_ch.last           = last_ff;

   // decode the addressed timer and read the store at one address
   always_comb begin
      in_range  = int'(idx_ff) < NUM_TIMERS;
      tgt       = TMR_W'(idx_ff);
      arm_live  = (value_ff != '0) || (per_ff != '0);
      rd_addr   = (state_ff == ST_FIRE) ? cand_ff : scan_idx_ff;
      rd_dl     = deadline_mem[rd_addr];
      rd_per    = period_mem[rd_addr];
      scan_last = (scan_idx_ff == TMR_W'(NUM_TIMERS - 1));
      hit_min   = armed_ff[scan_idx_ff] && (rd_dl < min_ff);
      hit_due   = armed_ff[scan_idx_ff] && !done_ff[scan_idx_ff] && (rd_dl <= now_ff)
                  && (!found_ff || (rd_dl < cand_dl_ff));
      found_fin = found_ff || hit_due;
   end

   // steer the shared adder
   always_comb begin
      case (state_ff)
         ST_APPLY: begin
            alu_req.mode = abs_ff ? ALU_ADD_RAW : ALU_ADD_SAT;
            alu_req.a    = {1'b0, value_ff};
            alu_req.b    = {1'b0, now_ff};
         end
         ST_REAL: begin
            alu_req.mode = ALU_SUB_CLAMP;
            alu_req.a    = sum_ff;
            alu_req.b    = {1'b0, real_now_ff};
         end
         default: begin
            alu_req.mode = ALU_ADD_SAT;
            alu_req.a    = {1'b0, now_ff};
            alu_req.b    = {1'b0, rd_per};
         end
      endcase
   end

   // next state and sequencing strobes
   always_comb begin
      state_in     = state_ff;
      scan_to_emit = 1'b0;
      emit_last    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_ch.op == OP_TICK) ? ST_SCAN : ST_APPLY;
            end
         end
         ST_APPLY: begin
            if ((op_ff == OP_ARM) && in_range && arm_live && abs_ff
                && mask_bit(realclk_ff, tgt)) begin
               state_in = ST_REAL;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_REAL: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) begin
               if ((op_ff != OP_TICK) || have_res_ff || !found_fin) begin
                  state_in     = ST_EMIT;
                  scan_to_emit = 1'b1;
                  if ((op_ff == OP_TICK) && have_res_ff) begin
                     emit_last = !found_fin || (count_ff == CNT_W'(MAX_RESULTS));
                  end
               end else begin
                  state_in = ST_FIRE;
               end
            end
         end
         ST_FIRE: begin
            state_in = ST_SCAN;
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               state_in = last_ff ? ST_IDLE : ST_FIRE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      scan_start = (state_in == ST_SCAN) && (state_ff != ST_SCAN);
   end

   // hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff  <= '0;
         wake_ff    <= '0;
         realclk_ff <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_LAUNCH:  launch_ff  <= csr_ch.data;
            REG_WAKE:    wake_ff    <= csr_ch.data;
            REG_REALCLK: realclk_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // capture the request word
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= req_ch.op;
         idx_ff      <= req_ch.timer_index;
         abs_ff      <= req_ch.absolute;
         value_ff    <= req_ch.start_value;
         per_ff      <= req_ch.period;
         now_ff      <= req_ch.now;
         real_now_ff <= req_ch.real_now;
      end
   end

   // apply operations and firings to the armed and busy bits
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= '0;
         busy_ff     <= '0;
         done_ff     <= '0;
         count_ff    <= '0;
         have_res_ff <= 1'b0;
      end else begin
         if (req_take) begin
            done_ff     <= '0;
            count_ff    <= '0;
            have_res_ff <= 1'b0;
         end
         if ((state_ff == ST_APPLY) && in_range) begin
            case (op_ff)
               OP_ARM:    armed_ff[tgt] <= arm_live && !(abs_ff && mask_bit(realclk_ff, tgt));
               OP_DISARM: armed_ff[tgt] <= 1'b0;
               OP_DONE:   busy_ff[tgt]  <= 1'b0;
               default: begin
               end
            endcase
         end
         if (state_ff == ST_REAL) begin
            armed_ff[tgt] <= 1'b1;
         end
         if (state_ff == ST_FIRE) begin
            done_ff[cand_ff]  <= 1'b1;
            count_ff          <= count_ff + 1'b1;
            have_res_ff       <= 1'b1;
            armed_ff[cand_ff] <= (rd_per != '0);
            if (!mask_bit(wake_ff, cand_ff) && mask_bit(launch_ff, cand_ff)) begin
               busy_ff[cand_ff] <= 1'b1;
            end
         end
      end
   end

   // write deadlines and periods
   always_ff @(posedge clock) begin
      if ((state_ff == ST_APPLY) && in_range && (op_ff == OP_ARM)) begin
         period_mem[tgt] <= per_ff;
         if (!abs_ff) begin
            deadline_mem[tgt] <= alu_y[TIME_W-1:0];
         end else begin
            deadline_mem[tgt] <= value_ff;
         end
         sum_ff <= alu_y;
      end
      if (state_ff == ST_REAL) begin
         deadline_mem[tgt] <= alu_y[TIME_W-1:0];
      end
      if ((state_ff == ST_FIRE) && (rd_per != '0)) begin
         deadline_mem[cand_ff] <= alu_y[TIME_W-1:0];
      end
   end

   // walk the timers: track the earliest armed and the earliest due
   always_ff @(posedge clock) begin
      if (scan_start) begin
         scan_idx_ff <= '0;
         min_ff      <= NEVER;
         found_ff    <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         scan_idx_ff <= scan_last ? '0 : scan_idx_ff + 1'b1;
         if (hit_min) begin
            min_ff <= rd_dl;
         end
         if (hit_due) begin
            found_ff   <= 1'b1;
            cand_ff    <= scan_idx_ff;
            cand_dl_ff <= rd_dl;
         end
      end
   end

   // load the result word
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIRE) begin
         fd_ff    <= rd_dl;
         fired_ff <= IDX_W'(cand_ff);
         if (mask_bit(wake_ff, cand_ff)) begin
            ev_ff <= EV_WAKE;
         end else if (mask_bit(launch_ff, cand_ff)) begin
            ev_ff <= busy_ff[cand_ff] ? EV_BUSY : EV_LAUNCH;
         end else begin
            ev_ff <= EV_DONE;
         end
      end
      if (scan_to_emit) begin
         last_ff <= emit_last;
         if (!((op_ff == OP_TICK) && have_res_ff)) begin
            ev_ff    <= EV_DONE;
            fd_ff    <= '0;
            fired_ff <= (op_ff == OP_TICK) ? '0 : idx_ff;
         end
      end
   end

endmodule
